@@ design/ypr_pkg.sv @@
// Package for the yaw/pitch point rotator: widths, types, the CORDIC arctangent
// table, the compensated CORDIC gain and the output saturation helper.
// Depends on nothing; every other design file imports it.
`default_nettype none

package ypr_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int ANGLE_WIDTH     = 16;
  localparam int ROTATION_STAGES = 16;

  localparam int ATAN_LEN   = 24;
  localparam int NUM_STAGES = (ROTATION_STAGES < ATAN_LEN) ? ROTATION_STAGES : ATAN_LEN;
  localparam int ATAN_IDX_W = 5;
  localparam int TRIG_W     = 32;
  localparam int PHASE_W    = 32;
  localparam int FRAC_SHIFT = 30;
  localparam int LO_BITS    = 16;
  localparam int MIX_W      = COORD_WIDTH + 2;
  localparam int HI_BITS    = MIX_W - LO_BITS;
  localparam int PROD_W     = MIX_W + TRIG_W;

  typedef logic signed [COORD_WIDTH-1:0]     coord_t;
  typedef logic signed [ANGLE_WIDTH-1:0]     angle_t;
  typedef logic signed [TRIG_W-1:0]          trig_t;
  typedef logic signed [PHASE_W-1:0]         phase_t;
  typedef logic signed [MIX_W-1:0]           wide_t;
  typedef logic signed [LO_BITS+TRIG_W:0]    lo_prod_t;
  typedef logic signed [HI_BITS+TRIG_W-1:0]  hi_prod_t;
  typedef logic signed [PROD_W-1:0]          prod_full_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    trig_t  cx;
    trig_t  cy;
    phase_t z;
    logic   neg;
  } cordic_lane_t;

  typedef struct packed {
    point_t       pt;
    cordic_lane_t yaw;
    cordic_lane_t pitch;
  } cordic_word_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
    trig_t ns;
  } trig_pair_t;

  typedef struct packed {
    wide_t      keep;
    trig_pair_t pair;
  } rot_side_t;

  typedef struct packed {
    wide_t      a;
    wide_t      b;
    trig_pair_t pair;
    rot_side_t  side;
  } rot_in_t;

  typedef struct packed {
    wide_t     a;
    wide_t     b;
    rot_side_t side;
  } rot_out_t;

  localparam trig_t      TRIG_ONE       = trig_t'(1 << FRAC_SHIFT);
  localparam trig_t      TRIG_MINUS_ONE = -TRIG_ONE;
  localparam phase_t     PHASE_HALF_PI  = phase_t'(1 << FRAC_SHIFT);
  localparam prod_full_t ROUND_BIAS     = prod_full_t'(1) << (FRAC_SHIFT - 1);
  localparam coord_t     COORD_MAX      = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t     COORD_MIN      = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  function automatic phase_t atan_phase(input logic [ATAN_IDX_W-1:0] idx);
    phase_t a;
    case (idx)
      5'd0:    a = phase_t'(536870912);
      5'd1:    a = phase_t'(316933406);
      5'd2:    a = phase_t'(167458907);
      5'd3:    a = phase_t'(85004756);
      5'd4:    a = phase_t'(42667331);
      5'd5:    a = phase_t'(21354465);
      5'd6:    a = phase_t'(10679838);
      5'd7:    a = phase_t'(5340245);
      5'd8:    a = phase_t'(2670163);
      5'd9:    a = phase_t'(1335087);
      5'd10:   a = phase_t'(667544);
      5'd11:   a = phase_t'(333772);
      5'd12:   a = phase_t'(166886);
      5'd13:   a = phase_t'(83443);
      5'd14:   a = phase_t'(41722);
      5'd15:   a = phase_t'(20861);
      5'd16:   a = phase_t'(10430);
      5'd17:   a = phase_t'(5215);
      5'd18:   a = phase_t'(2608);
      5'd19:   a = phase_t'(1304);
      5'd20:   a = phase_t'(652);
      5'd21:   a = phase_t'(326);
      5'd22:   a = phase_t'(163);
      5'd23:   a = phase_t'(81);
      default: a = '0;
    endcase
    return a;
  endfunction

  // The squared gain is reduced stage by stage in Q60 with truncating
  // quotients, then its integer square root gives the gain in Q30.
  function automatic logic [63:0] gain_q30();
    logic [63:0] k2;
    logic [63:0] quo;
    logic [63:0] dvs;
    logic [64:0] rem;
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bit_v;
    k2 = 64'd1 << 60;
    for (int i = 0; i < NUM_STAGES; i++) begin
      dvs = (64'd1 << (2 * i)) + 64'd1;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[63:0], k2[b]};
        if (rem >= {1'b0, dvs}) begin
          rem    = rem - {1'b0, dvs};
          quo[b] = 1'b1;
        end
      end
      k2 = k2 - quo;
    end
    n     = k2;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bit_v > n) begin
        bit_v = bit_v >> 2;
      end
    end
    for (int j = 0; j < 32; j++) begin
      if (bit_v != 64'd0) begin
        if (n >= res + bit_v) begin
          n   = n - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  localparam logic [63:0] GAIN_RAW    = gain_q30();
  localparam trig_t       CORDIC_GAIN = GAIN_RAW[TRIG_W-1:0];

  function automatic coord_t sat_coord(input wide_t v);
    coord_t r;
    if (v > wide_t'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < wide_t'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/ypr_if.sv @@
// Stream interfaces of the rotator: the point/angle input channel and the
// rotated point output channel, each with valid/ready. Depends on ypr_pkg.
`default_nettype none

interface ypr_in_if;
  import ypr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  angle_t yaw_angle;
  angle_t pitch_angle;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output yaw_angle, output pitch_angle, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input yaw_angle, input pitch_angle, output ready);
endinterface

interface ypr_out_if;
  import ypr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t rot_x;
  coord_t rot_y;
  coord_t rot_z;

  modport source (output valid, output rot_x, output rot_y, output rot_z, input ready);
  modport sink   (input valid, input rot_x, input rot_y, input rot_z, output ready);
endinterface

`default_nettype wire

@@ design/ypr_cordic_cell.sv @@
// One CORDIC micro-rotation cell, applied to the yaw and pitch lanes at once,
// with the point carried alongside. Depends on ypr_pkg.
`default_nettype none

module ypr_cordic_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [ypr_pkg::ATAN_IDX_W-1:0]     stage_idx,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ypr_pkg::cordic_word_t              in_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ypr_pkg::cordic_word_t              out_word
);
  import ypr_pkg::*;

  function automatic cordic_lane_t cell_step(input cordic_lane_t l,
                                             input logic [ATAN_IDX_W-1:0] idx);
    cordic_lane_t r;
    trig_t        sx;
    trig_t        sy;
    phase_t       ang;
    sx    = l.cx >>> idx;
    sy    = l.cy >>> idx;
    ang   = atan_phase(idx);
    r.neg = l.neg;
    if (!l.z[PHASE_W-1]) begin
      r.cx = l.cx - sy;
      r.cy = l.cy + sx;
      r.z  = l.z - ang;
    end else begin
      r.cx = l.cx + sy;
      r.cy = l.cy - sx;
      r.z  = l.z + ang;
    end
    return r;
  endfunction

  logic         valid_r;
  cordic_word_t word_r;
  cordic_word_t word_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_comb begin
    word_nxt.pt    = in_word.pt;
    word_nxt.yaw   = cell_step(in_word.yaw, stage_idx);
    word_nxt.pitch = cell_step(in_word.pitch, stage_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/ypr_plane_rot.sv @@
// Planar rotation unit: a' = a*c + b*s, b' = a*(-s) + b*c with Q30 trig and
// round-half-up products, in three stages (partial products, round, sum).
// Depends on ypr_pkg.
`default_nettype none

module ypr_plane_rot (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ypr_pkg::rot_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ypr_pkg::rot_out_t out_data
);
  import ypr_pkg::*;

  localparam int NTERM = 4;

  logic       valid_r [3];
  logic       rdy [3];

  wide_t      op_a [NTERM];
  trig_t      op_t [NTERM];
  lo_prod_t   lo_nxt [NTERM];
  hi_prod_t   hi_nxt [NTERM];
  lo_prod_t   lo_r [NTERM];
  hi_prod_t   hi_r [NTERM];
  prod_full_t full [NTERM];
  wide_t      term_nxt [NTERM];
  wide_t      term_r [NTERM];
  rot_side_t  side_p_r;
  rot_side_t  side_t_r;
  rot_side_t  side_s_r;
  wide_t      a_r;
  wide_t      b_r;

  assign rdy[2]    = !valid_r[2] || out_ready;
  assign rdy[1]    = !valid_r[1] || rdy[2];
  assign rdy[0]    = !valid_r[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = valid_r[2];

  always_comb begin
    out_data.a    = a_r;
    out_data.b    = b_r;
    out_data.side = side_s_r;
  end

  always_comb begin
    op_a[0] = in_data.a;  op_t[0] = in_data.pair.c;
    op_a[1] = in_data.b;  op_t[1] = in_data.pair.s;
    op_a[2] = in_data.a;  op_t[2] = in_data.pair.ns;
    op_a[3] = in_data.b;  op_t[3] = in_data.pair.c;
    for (int k = 0; k < NTERM; k++) begin
      lo_nxt[k] = lo_prod_t'($signed({1'b0, op_a[k][LO_BITS-1:0]})) * lo_prod_t'(op_t[k]);
      hi_nxt[k] = hi_prod_t'($signed(op_a[k][MIX_W-1:LO_BITS])) * hi_prod_t'(op_t[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < NTERM; k++) begin
      full[k]     = (prod_full_t'(hi_r[k]) <<< LO_BITS) + prod_full_t'(lo_r[k]) + ROUND_BIAS;
      term_nxt[k] = full[k][FRAC_SHIFT +: MIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
      valid_r[1] <= 1'b0;
      valid_r[2] <= 1'b0;
    end else begin
      if (rdy[0]) begin
        valid_r[0] <= in_valid;
      end
      if (rdy[1]) begin
        valid_r[1] <= valid_r[0];
      end
      if (rdy[2]) begin
        valid_r[2] <= valid_r[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      side_p_r <= in_data.side;
    end
    if (rdy[1] && valid_r[0]) begin
      term_r   <= term_nxt;
      side_t_r <= side_p_r;
    end
    if (rdy[2] && valid_r[1]) begin
      a_r      <= term_r[0] + term_r[1];
      b_r      <= term_r[2] + term_r[3];
      side_s_r <= side_t_r;
    end
  end

endmodule

`default_nettype wire

@@ design/yaw_pitch_point_rotator_core.sv @@
// Top level of the yaw/pitch point rotator: angle folding, the CORDIC cell
// chain, sine/cosine finishing, two planar rotation units and the output register.
// Depends on ypr_pkg, ypr_if, ypr_cordic_cell and ypr_plane_rot.
//
//   Channel   Modport           Contents
//   in_ch     ypr_in_if.sink    pos_x, pos_y, pos_z (Q16.16), yaw_angle, pitch_angle
//   out_ch    ypr_out_if.source rot_x, rot_y, rot_z (Q16.16, saturated)
//
// One item is accepted per cycle unless out_ch.ready holds back a result.
// The chain holds the CORDIC cells, one micro-rotation per cell.
// Reset is synchronous and clears only the valid flags of the stages.
// Ready travels back through every stage, so empty stages fill while the
// output register holds a result that has not been taken.
`default_nettype none

module yaw_pitch_point_rotator_core (
  input  logic             clk,
  input  logic             rst_n,
  ypr_in_if.sink           in_ch,
  ypr_out_if.source        out_ch
);
  import ypr_pkg::*;

  typedef struct packed {
    point_t     pt;
    trig_pair_t yaw;
    trig_pair_t pitch;
  } fin_t;

  function automatic cordic_lane_t fold_lane(input angle_t ang);
    cordic_lane_t l;
    phase_t       p;
    p     = $signed({ang, {(PHASE_W-ANGLE_WIDTH){1'b0}}});
    l.neg = (p > PHASE_HALF_PI) || (p < -PHASE_HALF_PI);
    l.z   = l.neg ? $signed({~p[PHASE_W-1], p[PHASE_W-2:0]}) : p;
    l.cx  = CORDIC_GAIN;
    l.cy  = '0;
    return l;
  endfunction

  function automatic trig_t clamp_trig(input trig_t v);
    trig_t r;
    if (v > TRIG_ONE) begin
      r = TRIG_ONE;
    end else if (v < TRIG_MINUS_ONE) begin
      r = TRIG_MINUS_ONE;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic trig_pair_t finish_lane(input cordic_lane_t l);
    trig_pair_t tp;
    tp.c  = clamp_trig(l.neg ? -l.cx : l.cx);
    tp.s  = clamp_trig(l.neg ? -l.cy : l.cy);
    tp.ns = clamp_trig(l.neg ? l.cy : -l.cy);
    return tp;
  endfunction

  // Entry stage.
  logic         ent_valid_r;
  cordic_word_t ent_r;
  cordic_word_t ent_nxt;
  logic         ent_rdy;

  // Cell chain.
  logic         chain_valid [NUM_STAGES+1];
  logic         chain_ready [NUM_STAGES+1];
  cordic_word_t chain_word  [NUM_STAGES+1];

  // Finishing stage.
  logic         fin_valid_r;
  fin_t         fin_r;
  fin_t         fin_nxt;
  logic         fin_rdy;

  // Rotation units.
  rot_in_t      r1_in;
  rot_out_t     r1_out;
  logic         r1_in_ready;
  logic         r1_out_valid;
  rot_in_t      r2_in;
  rot_out_t     r2_out;
  logic         r2_in_ready;
  logic         r2_out_valid;

  // Output register.
  logic         out_valid_r;
  logic         out_rdy;
  point_t       out_r;
  point_t       out_nxt;

  assign ent_rdy     = !ent_valid_r || chain_ready[0];
  assign in_ch.ready = ent_rdy;

  always_comb begin
    ent_nxt.pt.x  = in_ch.pos_x;
    ent_nxt.pt.y  = in_ch.pos_y;
    ent_nxt.pt.z  = in_ch.pos_z;
    ent_nxt.yaw   = fold_lane(in_ch.yaw_angle);
    ent_nxt.pitch = fold_lane(in_ch.pitch_angle);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else if (ent_rdy) begin
      ent_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_rdy && in_ch.valid) begin
      ent_r <= ent_nxt;
    end
  end

  assign chain_valid[0]          = ent_valid_r;
  assign chain_word[0]           = ent_r;
  assign chain_ready[NUM_STAGES] = fin_rdy;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cell
    ypr_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (ATAN_IDX_W'(k)),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_word   (chain_word[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_word  (chain_word[k+1])
    );
  end

  assign fin_rdy = !fin_valid_r || r1_in_ready;

  always_comb begin
    fin_nxt.pt    = chain_word[NUM_STAGES].pt;
    fin_nxt.yaw   = finish_lane(chain_word[NUM_STAGES].yaw);
    fin_nxt.pitch = finish_lane(chain_word[NUM_STAGES].pitch);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fin_rdy) begin
      fin_valid_r <= chain_valid[NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_rdy && chain_valid[NUM_STAGES]) begin
      fin_r <= fin_nxt;
    end
  end

  always_comb begin
    r1_in.a         = wide_t'(fin_r.pt.x);
    r1_in.b         = wide_t'(fin_r.pt.y);
    r1_in.pair      = fin_r.yaw;
    r1_in.side.keep = wide_t'(fin_r.pt.z);
    r1_in.side.pair = fin_r.pitch;
  end

  ypr_plane_rot u_yaw_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fin_valid_r),
    .in_ready  (r1_in_ready),
    .in_data   (r1_in),
    .out_valid (r1_out_valid),
    .out_ready (r2_in_ready),
    .out_data  (r1_out)
  );

  always_comb begin
    r2_in.a         = r1_out.a;
    r2_in.b         = r1_out.side.keep;
    r2_in.pair      = r1_out.side.pair;
    r2_in.side.keep = r1_out.b;
    r2_in.side.pair = r1_out.side.pair;
  end

  ypr_plane_rot u_pitch_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (r1_out_valid),
    .in_ready  (r2_in_ready),
    .in_data   (r2_in),
    .out_valid (r2_out_valid),
    .out_ready (out_rdy),
    .out_data  (r2_out)
  );

  assign out_rdy = !out_valid_r || out_ch.ready;

  always_comb begin
    out_nxt.x = sat_coord(r2_out.a);
    out_nxt.y = sat_coord(r2_out.side.keep);
    out_nxt.z = sat_coord(r2_out.b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= r2_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && r2_out_valid) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.rot_x = out_r.x;
  assign out_ch.rot_y = out_r.y;
  assign out_ch.rot_z = out_r.z;

endmodule

`default_nettype wire

@@ design/ypr_checker.sv @@
// Port-level checks for the rotator core and the bind that attaches them.
// Depends on ypr_pkg and yaw_pitch_point_rotator_core.
`default_nettype none

module ypr_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input ypr_pkg::coord_t rot_x,
  input ypr_pkg::coord_t rot_y,
  input ypr_pkg::coord_t rot_z
);
  import ypr_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A result that is not taken keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(rot_x) && $stable(rot_y) && $stable(rot_z))
    else $error("result item changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item offered right after reset");

  // With the output register free, the whole chain can move, so an item is taken.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked although the output side can move");

  // No item can leave the pipeline in the cycle after reset is released.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result item without an accepted input item");

endmodule

bind yaw_pitch_point_rotator_core ypr_checker u_ypr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .rot_x     (out_ch.rot_x),
  .rot_y     (out_ch.rot_y),
  .rot_z     (out_ch.rot_z)
);

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for yaw_pitch_point_rotator_core: a short table of
// directed points, then random points in phases of idling and stalling.
// Depends on ypr_pkg, ypr_if and the rotator RTL.
module tb_top;
  import ypr_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    angle_t yaw;
    angle_t pitch;
  } point_item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } rotated_t;

  typedef struct packed {
    bit       typed;
    rotated_t want;
  } typed_entry_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    angle_t yaw;
    angle_t pitch;
    bit     typed;
    coord_t ex;
    coord_t ey;
    coord_t ez;
  } dir_row_t;

  localparam int     SIN_STAGES = (ROTATION_STAGES < 24) ? ROTATION_STAGES : 24;
  localparam longint UNIT_Q30   = 64'sd1 <<< 30;
  localparam longint HALF_TURN  = 64'sd1 <<< 31;
  localparam int     LIMIT_TIME = 3000000;

  localparam longint ATAN_Q31 [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  localparam coord_t ONE_Q16     = 32'sh0001_0000;
  localparam angle_t ANG_ZERO    = 16'sh0000;
  localparam angle_t ANG_EIGHTH  = 16'sh2000;
  localparam angle_t ANG_QUARTER = 16'sh4000;
  localparam angle_t ANG_NEG_PI  = 16'sh8000;
  localparam angle_t ANG_MAX     = 16'sh7FFF;

  localparam angle_t ANGLE_MARKS [8] = '{
    ANG_ZERO, ANG_NEG_PI, ANG_MAX, ANG_QUARTER, -ANG_QUARTER,
    ANG_QUARTER + 16'sd1, -ANG_QUARTER - 16'sd1, ANG_EIGHTH
  };

  // The first four rows expect a zero point to stay at zero; the others use rotate_point.
  localparam dir_row_t DIRECTED [20] = '{
    '{32'sd0, 32'sd0, 32'sd0, ANG_ZERO, ANG_ZERO, 1'b1, 32'sd0, 32'sd0, 32'sd0},
    '{32'sd0, 32'sd0, 32'sd0, ANG_NEG_PI, ANG_NEG_PI, 1'b1, 32'sd0, 32'sd0, 32'sd0},
    '{32'sd0, 32'sd0, 32'sd0, ANG_MAX, ANG_MAX, 1'b1, 32'sd0, 32'sd0, 32'sd0},
    '{32'sd0, 32'sd0, 32'sd0, ANG_QUARTER, -ANG_QUARTER, 1'b1, 32'sd0, 32'sd0, 32'sd0},
    '{ONE_Q16, 32'sd0, 32'sd0, ANG_ZERO, ANG_ZERO, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, ANG_NEG_PI, ANG_ZERO, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, ANG_ZERO, ANG_NEG_PI, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{ONE_Q16, -ONE_Q16, ONE_Q16, ANG_QUARTER, ANG_QUARTER, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{ONE_Q16, -ONE_Q16, ONE_Q16, ANG_QUARTER + 16'sd1, -ANG_QUARTER - 16'sd1, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{-ONE_Q16, ONE_Q16, -ONE_Q16, -ANG_QUARTER, ANG_QUARTER + 16'sd1, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{COORD_MAX, COORD_MAX, COORD_MAX, ANG_EIGHTH, ANG_EIGHTH, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{COORD_MIN, COORD_MIN, COORD_MIN, ANG_EIGHTH, ANG_EIGHTH, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{COORD_MIN, COORD_MAX, COORD_MIN, ANG_EIGHTH, -ANG_EIGHTH, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{COORD_MAX, COORD_MIN, COORD_MAX, ANG_NEG_PI, ANG_MAX, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{COORD_MIN, COORD_MIN, COORD_MIN, ANG_NEG_PI, ANG_NEG_PI, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{COORD_MAX, COORD_MAX, COORD_MAX, ANG_MAX, ANG_NEG_PI + 16'sd1, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{-32'sd1, -32'sd1, -32'sd1, 16'sd1, -16'sd1, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{32'sh1234_5678, 32'shEDCB_A988, ONE_Q16, 16'sh2AAA, 16'shD555, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{COORD_MIN, 32'sd0, COORD_MAX, ANG_ZERO, ANG_ZERO, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{32'sd0, COORD_MIN, 32'sd0, ANG_QUARTER, ANG_ZERO, 1'b0, 32'sd0, 32'sd0, 32'sd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  ypr_in_if  in_ch ();
  ypr_out_if out_ch ();

  yaw_pitch_point_rotator_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typed_entry_t typed_due [$];
  rotated_t     rotations_due [$];
  int           mismatch_count = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           long_hold      = 0;

  // Sine and cosine in Q30 from a CORDIC whose start vector carries the gain.
  function automatic void angle_trig(input angle_t ang, output longint c, output longint s);
    longint unsigned k2;
    longint unsigned res;
    longint unsigned bitv;
    longint          x;
    longint          y;
    longint          z;
    longint          nx;
    bit              flip;
    k2 = 64'd1 << 60;
    for (int i = 0; i < SIN_STAGES; i++) begin
      k2 = k2 - k2 / ((64'd1 << (2 * i)) + 64'd1);
    end
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > k2) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (k2 >= res + bitv) begin
        k2  = k2 - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    x    = longint'(res);
    y    = 0;
    z    = longint'(ang) <<< (32 - ANGLE_WIDTH);
    flip = 1'b0;
    if (z > UNIT_Q30) begin
      z    = z - HALF_TURN;
      flip = 1'b1;
    end else if (z < -UNIT_Q30) begin
      z    = z + HALF_TURN;
      flip = 1'b1;
    end
    for (int i = 0; i < SIN_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_Q31[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_Q31[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x > UNIT_Q30) ? UNIT_Q30 : ((x < -UNIT_Q30) ? -UNIT_Q30 : x);
    s = (y > UNIT_Q30) ? UNIT_Q30 : ((y < -UNIT_Q30) ? -UNIT_Q30 : y);
  endfunction

  // Coordinate times Q30 factor, rounded to nearest with ties upward.
  function automatic longint scale_trig(input longint c, input longint t);
    logic signed [127:0] cw;
    logic signed [127:0] tw;
    logic signed [127:0] p;
    cw = c;
    tw = t;
    p  = cw * tw + (128'sd1 <<< 29);
    return longint'(p >>> 30);
  endfunction

  function automatic coord_t clip_coord(input longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic rotated_t rotate_point(input point_item_t p);
    longint   ca;
    longint   sa;
    longint   cb;
    longint   sb;
    longint   x1;
    longint   y1;
    rotated_t r;
    angle_trig(p.yaw, ca, sa);
    angle_trig(p.pitch, cb, sb);
    x1  = scale_trig(p.x, ca) + scale_trig(p.y, sa);
    y1  = scale_trig(p.x, -sa) + scale_trig(p.y, ca);
    r.x = clip_coord(scale_trig(x1, cb) + scale_trig(p.z, sb));
    r.y = clip_coord(y1);
    r.z = clip_coord(scale_trig(x1, -sb) + scale_trig(p.z, cb));
    return r;
  endfunction

  function automatic coord_t rand_coord();
    coord_t v;
    v = coord_t'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = v;
      5, 6, 7: v = v >>> $urandom_range(30, 8);
      8: v = $urandom_range(1) ? COORD_MAX : COORD_MIN;
      default: v = coord_t'($urandom_range(2)) - coord_t'(1);
    endcase
    return v;
  endfunction

  function automatic angle_t rand_angle();
    if ($urandom_range(7) == 0) return ANGLE_MARKS[$urandom_range(7)];
    return angle_t'($urandom);
  endfunction

  task automatic send_point(input point_item_t pt, input bit typed, input rotated_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    typed_due.push_back('{typed, want});
    in_ch.valid       <= 1'b1;
    in_ch.pos_x       <= pt.x;
    in_ch.pos_y       <= pt.y;
    in_ch.pos_z       <= pt.z;
    in_ch.yaw_angle   <= pt.yaw;
    in_ch.pitch_angle <= pt.pitch;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_rotations();
    in_ch.valid <= 1'b0;
    while (rotations_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                           input int hold);
    point_item_t pt;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    long_hold      = hold;
    repeat (count) begin
      pt.x     = rand_coord();
      pt.y     = rand_coord();
      pt.z     = rand_coord();
      pt.yaw   = rand_angle();
      pt.pitch = rand_angle();
      send_point(pt, 1'b0, '0);
    end
    drain_rotations();
  endtask

  always @(negedge clk) begin
    if (long_hold > 0) begin
      out_ch.ready <= 1'b0;
      long_hold--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  typed_entry_t head_tag;
  point_item_t  seen_point;
  rotated_t     exp_rot;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        head_tag         = typed_due.pop_front();
        seen_point.x     = in_ch.pos_x;
        seen_point.y     = in_ch.pos_y;
        seen_point.z     = in_ch.pos_z;
        seen_point.yaw   = in_ch.yaw_angle;
        seen_point.pitch = in_ch.pitch_angle;
        rotations_due.push_back(head_tag.typed ? head_tag.want : rotate_point(seen_point));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (rotations_due.size() == 0) begin
          $error("rotated point arrived with no item pending");
          mismatch_count++;
        end else begin
          exp_rot = rotations_due.pop_front();
          if (out_ch.rot_x !== exp_rot.x) begin
            $error("rot_x: expected %0d, actual %0d", exp_rot.x, out_ch.rot_x);
            mismatch_count++;
          end
          if (out_ch.rot_y !== exp_rot.y) begin
            $error("rot_y: expected %0d, actual %0d", exp_rot.y, out_ch.rot_y);
            mismatch_count++;
          end
          if (out_ch.rot_z !== exp_rot.z) begin
            $error("rot_z: expected %0d, actual %0d", exp_rot.z, out_ch.rot_z);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    point_item_t pt;
    rotated_t    want;
    in_ch.valid       = 1'b0;
    in_ch.pos_x       = '0;
    in_ch.pos_y       = '0;
    in_ch.pos_z       = '0;
    in_ch.yaw_angle   = '0;
    in_ch.pitch_angle = '0;
    out_ch.ready      = 1'b0;
    rst_n             = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      pt.x     = DIRECTED[i].x;
      pt.y     = DIRECTED[i].y;
      pt.z     = DIRECTED[i].z;
      pt.yaw   = DIRECTED[i].yaw;
      pt.pitch = DIRECTED[i].pitch;
      want.x   = DIRECTED[i].ex;
      want.y   = DIRECTED[i].ey;
      want.z   = DIRECTED[i].ez;
      send_point(pt, DIRECTED[i].typed, want);
    end
    drain_rotations();

    run_phase(240, 0, 0, 0);
    run_phase(240, 73, 0, 0);
    run_phase(240, 0, 73, 0);
    run_phase(240, 26, 26, 0);
    // The receiver holds off long enough for the pipeline to fill and stall input.
    run_phase(240, 0, 0, 300);

    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #LIMIT_TIME;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ yaw_pitch_point_rotator_core.f @@
design/ypr_pkg.sv
design/ypr_if.sv
design/ypr_cordic_cell.sv
design/ypr_plane_rot.sv
design/yaw_pitch_point_rotator_core.sv
design/ypr_checker.sv
dv/tb_top.sv
